// ===== rtl/rcf_pkg.sv =====
// Shared types, constants and helper functions of the RGB 3x3 convolution filter.
// No dependencies; the interfaces, window, kernel and top level use this package.
package rcf_pkg;

	localparam int CH_W        = 8;
	localparam int NUM_CH      = 3;
	localparam int NUM_TAPS    = 9;
	localparam int NUM_KINDS   = 15;
	localparam int PIX_MAX     = 255;
	localparam int KIND_W      = 4;
	localparam int WIDTH_W     = 12;
	localparam int HEIGHT_W    = 13;
	localparam int ROW_W       = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int MIN_DIM     = 3;
	localparam int MAX_HEIGHT  = 4096;
	localparam int BORDER      = 1;
	localparam int RECIP_SHIFT = 20;

	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_KIND  = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	localparam logic [KIND_W-1:0] KIND_MEAN    = 4'd0;
	localparam logic [KIND_W-1:0] KIND_CROSS   = 4'd1;
	localparam logic [KIND_W-1:0] KIND_GAUSS   = 4'd4;
	localparam logic [KIND_W-1:0] KIND_SOFT    = 4'd5;
	localparam logic [KIND_W-1:0] KIND_PREWITT = 4'd9;
	localparam logic [KIND_W-1:0] KIND_SOBEL   = 4'd11;
	localparam logic [KIND_W-1:0] KIND_UNUSED  = 4'd15;
	localparam logic [KIND_W-1:0] DUAL_OFFSET  = 4'd3;

	typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

	typedef struct packed {
		rgb_t [NUM_TAPS-1:0] pix;
		logic                frame_end;
	} win_t;

	typedef logic signed [4:0]  coef_t;
	typedef logic signed [12:0] prod_t;
	typedef logic signed [13:0] sum_t;
	typedef logic        [12:0] mag_t;
	typedef logic        [20:0] recip_t;
	typedef logic        [33:0] quot_t;

	localparam coef_t KERNELS [NUM_KINDS][NUM_TAPS] = '{
		'{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
		'{ 5'sd0,  5'sd1,  5'sd0,  5'sd1,  5'sd1,  5'sd1,  5'sd0,  5'sd1,  5'sd0},
		'{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
		'{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
		'{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
		'{ 5'sd0,  5'sd1,  5'sd0,  5'sd1,  5'sd2,  5'sd1,  5'sd0,  5'sd1,  5'sd0},
		'{ 5'sd0,  5'sd1,  5'sd0,  5'sd1, -5'sd4,  5'sd1,  5'sd0,  5'sd1,  5'sd0},
		'{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
		'{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd7, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
		'{-5'sd1, -5'sd1, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd1,  5'sd1},
		'{-5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd1},
		'{-5'sd1, -5'sd2, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd2,  5'sd1},
		'{ 5'sd1,  5'sd0, -5'sd1,  5'sd1,  5'sd0, -5'sd1,  5'sd1,  5'sd0, -5'sd1},
		'{ 5'sd0,  5'sd0, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd0,  5'sd0},
		'{-5'sd1,  5'sd0,  5'sd1, -5'sd2,  5'sd0,  5'sd2, -5'sd1,  5'sd0,  5'sd1}
	};

	// ceil(2^RECIP_SHIFT / divisor); exact floor division for magnitudes below 2^13
	localparam recip_t RECIP [NUM_KINDS] = '{
		21'd116509, 21'd209716, 21'd1048576, 21'd1048576, 21'd65536,
		21'd174763, 21'd1048576, 21'd1048576, 21'd349526, 21'd1048576,
		21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576
	};

	function automatic prod_t tap_mul(logic [CH_W-1:0] px, logic [KIND_W-1:0] kind,
		int unsigned k);
		prod_t a;
		prod_t b;
		a = prod_t'({5'b0, px});
		b = (kind < KIND_UNUSED) ? prod_t'(KERNELS[kind][k]) : '0;
		return a * b;
	endfunction

	function automatic mag_t rectify(sum_t s, logic grad);
		if (s < 0) begin
			return grad ? mag_t'(-s) : '0;
		end
		return mag_t'(s);
	endfunction

	function automatic recip_t recip_of(logic [KIND_W-1:0] kind);
		return (kind < KIND_UNUSED) ? RECIP[kind] : RECIP[0];
	endfunction

	function automatic logic [CH_W-1:0] clamp8(logic [13:0] x);
		return (x > 14'(PIX_MAX)) ? CH_W'(PIX_MAX) : x[CH_W-1:0];
	endfunction

endpackage

// ===== rtl/rcf_if.sv =====
// Valid/ready channel interfaces of the filter: pixel in, result out, config write.
// Depends on rcf_pkg for field widths.
interface rcf_pix_if;
	logic                      valid;
	logic                      ready;
	logic [rcf_pkg::CH_W-1:0]  red_in;
	logic [rcf_pkg::CH_W-1:0]  green_in;
	logic [rcf_pkg::CH_W-1:0]  blue_in;

	modport source(output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rcf_res_if;
	logic                      valid;
	logic                      ready;
	logic [rcf_pkg::CH_W-1:0]  red_out;
	logic [rcf_pkg::CH_W-1:0]  green_out;
	logic [rcf_pkg::CH_W-1:0]  blue_out;
	logic                      frame_end;

	modport source(output valid, output red_out, output green_out, output blue_out,
		output frame_end, input ready);
	modport sink(input valid, input red_out, input green_out, input blue_out,
		input frame_end, output ready);
endinterface

interface rcf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rcf_pkg::CFG_IDX_W-1:0]  index;
	logic [rcf_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/rcf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module rcf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;
endmodule

// ===== rtl/rcf_window.sv =====
// Raster counters, two line buffers and the 3x3 window shift registers (stages s1, s2).
// Depends on rcf_pkg, rcf_if and rcf_ram.
module rcf_window #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rcf_pix_if.sink                       pixel,
	input  logic [rcf_pkg::WIDTH_W-1:0]   image_width,
	input  logic [rcf_pkg::HEIGHT_W-1:0]  image_height,
	output logic                          win_valid,
	output rcf_pkg::win_t                 win_data,
	input  logic                          win_ready
);
	import rcf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int XW = (AW + 1 > HEIGHT_W) ? AW + 1 : HEIGHT_W;
	localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);

	logic [XW-1:0]    w_x;
	logic [XW-1:0]    h_x;
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             wrap_c;
	logic [XW-1:0]    row_inc;
	logic [AW-1:0]    col_cur;
	logic [ROW_W-1:0] row_cur;
	logic [XW-1:0]    col_nxt_x;
	logic [XW-1:0]    row_nxt_x;
	logic [AW-1:0]    col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic             emit;
	logic             fend;

	logic             clr_q;
	logic [AW-1:0]    clr_cnt_q;

	logic             v_s1;
	logic             v_s2;
	logic             load_s1;
	logic             load_s2;
	logic             acc;
	logic             adv_s1;
	rgb_t             cur_s1;
	logic [AW-1:0]    col_s1;
	logic             emit_s1;
	logic             fend_s1;
	win_t             win_s2;
	rgb_t             col_a_q [NUM_CH];
	rgb_t             col_b_q [NUM_CH];

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	rgb_t             mid_wdata;
	rgb_t             top_wdata;
	rgb_t             mid_rd;
	rgb_t             top_rd;

	// effective geometry and position of the pixel being accepted
	always_comb begin
		w_x = XW'(image_width);
		if (w_x < XW'(MIN_DIM)) begin
			w_x = XW'(MIN_DIM);
		end else if (w_x > MAX_W_X) begin
			w_x = MAX_W_X;
		end
		h_x = XW'(image_height);
		if (h_x < XW'(MIN_DIM)) begin
			h_x = XW'(MIN_DIM);
		end else if (h_x > XW'(MAX_HEIGHT)) begin
			h_x = XW'(MAX_HEIGHT);
		end

		wrap_c    = XW'(col_q) >= w_x;
		col_cur   = wrap_c ? '0 : col_q;
		row_inc   = XW'(row_q) + (wrap_c ? XW'(1) : XW'(0));
		row_cur   = (row_inc >= h_x) ? '0 : row_inc[ROW_W-1:0];
		col_nxt_x = XW'(col_cur) + XW'(1);
		row_nxt_x = XW'(row_cur) + XW'(1);
		if (col_nxt_x >= w_x) begin
			col_nxt = '0;
			row_nxt = (row_nxt_x >= h_x) ? '0 : row_nxt_x[ROW_W-1:0];
		end else begin
			col_nxt = col_nxt_x[AW-1:0];
			row_nxt = row_cur;
		end
		emit = (XW'(row_cur) > XW'(BORDER)) && (XW'(col_cur) > XW'(BORDER));
		fend = (XW'(row_cur) == h_x - XW'(1)) && (XW'(col_cur) == w_x - XW'(1));
	end

	assign load_s2     = !v_s2 || win_ready;
	assign load_s1     = !v_s1 || load_s2;
	assign pixel.ready = load_s1 && !clr_q;
	assign acc         = pixel.valid && pixel.ready;
	assign adv_s1      = v_s1 && load_s2;

	// line buffers: mid holds the previous row, top the row before it
	assign ram_we    = clr_q || adv_s1;
	assign ram_waddr = clr_q ? clr_cnt_q : col_s1;
	assign mid_wdata = clr_q ? '0 : cur_s1;
	assign top_wdata = clr_q ? '0 : mid_rd;

	rcf_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_mid_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mid_wdata),
		.re    (acc),
		.raddr (col_cur),
		.rdata (mid_rd)
	);

	rcf_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_top_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (top_wdata),
		.re    (acc),
		.raddr (col_cur),
		.rdata (top_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (acc) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
			if (clr_q) begin
				if (clr_cnt_q == AW'(MAX_WIDTH - 1)) begin
					clr_q <= 1'b0;
				end
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (load_s1) begin
				v_s1 <= acc;
			end
			if (load_s2) begin
				v_s2 <= v_s1 && emit_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_s1  <= {pixel.red_in, pixel.green_in, pixel.blue_in};
			col_s1  <= col_cur;
			emit_s1 <= emit;
			fend_s1 <= fend;
		end
		if (adv_s1) begin
			col_a_q[0] <= col_b_q[0];
			col_a_q[1] <= col_b_q[1];
			col_a_q[2] <= col_b_q[2];
			col_b_q[0] <= top_rd;
			col_b_q[1] <= mid_rd;
			col_b_q[2] <= cur_s1;
			win_s2.pix[0] <= col_a_q[0];
			win_s2.pix[1] <= col_b_q[0];
			win_s2.pix[2] <= top_rd;
			win_s2.pix[3] <= col_a_q[1];
			win_s2.pix[4] <= col_b_q[1];
			win_s2.pix[5] <= mid_rd;
			win_s2.pix[6] <= col_a_q[2];
			win_s2.pix[7] <= col_b_q[2];
			win_s2.pix[8] <= cur_s1;
			win_s2.frame_end <= fend_s1;
		end
	end

	assign win_valid = v_s2;
	assign win_data  = win_s2;

	// the line buffer read and the delayed write never hit the same column
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		acc && adv_s1 |-> col_cur != col_s1)
		else $error("line buffer read/write collision");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < MAX_WIDTH)
		else $error("column counter beyond line buffer depth");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_cnt_q) == AW'(MAX_WIDTH - 1))
		else $error("line buffer clear ended early");
endmodule

// ===== rtl/rcf_kernel.sv =====
// Kernel datapath: tap products, sums, rectify and divide, clamp and combine (s3..s6).
// Depends on rcf_pkg and rcf_if.
module rcf_kernel (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rcf_pkg::KIND_W-1:0]   kind,
	input  logic                         win_valid,
	input  rcf_pkg::win_t                win_data,
	output logic                         win_ready,
	rcf_res_if.source                    result
);
	import rcf_pkg::*;

	logic              dual;
	logic [KIND_W-1:0] kind_b;
	logic              grad_a;

	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic v_s6;
	logic load_s3;
	logic load_s4;
	logic load_s5;
	logic load_s6;

	prod_t          prod_s3 [2][NUM_CH][NUM_TAPS];
	logic           fend_s3;
	sum_t           sum_s4 [2][NUM_CH];
	logic           fend_s4;
	quot_t          quot_s5 [2][NUM_CH];
	logic           fend_s5;
	rgb_t           out_s6;
	logic           fend_s6;

	sum_t              sum_c [2][NUM_CH];
	logic [CH_W-1:0]   qa [NUM_CH];
	logic [CH_W-1:0]   qb [NUM_CH];
	logic [CH_W:0]     qsum [NUM_CH];
	rgb_t              out_c;

	assign dual    = (kind >= KIND_PREWITT) && (kind <= KIND_SOBEL);
	assign kind_b  = dual ? kind + DUAL_OFFSET : kind;
	assign grad_a  = kind >= KIND_PREWITT;

	assign load_s6   = !v_s6 || result.ready;
	assign load_s5   = !v_s5 || load_s6;
	assign load_s4   = !v_s4 || load_s5;
	assign load_s3   = !v_s3 || load_s4;
	assign win_ready = load_s3;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum_c[0][c] = '0;
			sum_c[1][c] = '0;
			for (int k = 0; k < NUM_TAPS; k++) begin
				sum_c[0][c] = sum_c[0][c] + sum_t'(prod_s3[0][c][k]);
				sum_c[1][c] = sum_c[1][c] + sum_t'(prod_s3[1][c][k]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			qa[c]   = clamp8(quot_s5[0][c][RECIP_SHIFT +: 14]);
			qb[c]   = clamp8(quot_s5[1][c][RECIP_SHIFT +: 14]);
			qsum[c] = {1'b0, qa[c]} + {1'b0, qb[c]};
			if (!dual) begin
				out_c[c] = qa[c];
			end else if (qsum[c] > (CH_W + 1)'(PIX_MAX)) begin
				out_c[c] = CH_W'(PIX_MAX);
			end else begin
				out_c[c] = qsum[c][CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (load_s3) v_s3 <= win_valid;
			if (load_s4) v_s4 <= v_s3;
			if (load_s5) v_s5 <= v_s4;
			if (load_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3 && win_valid) begin
			for (int c = 0; c < NUM_CH; c++) begin
				for (int k = 0; k < NUM_TAPS; k++) begin
					prod_s3[0][c][k] <= tap_mul(win_data.pix[k][c], kind, k);
					prod_s3[1][c][k] <= tap_mul(win_data.pix[k][c], kind_b, k);
				end
			end
			fend_s3 <= win_data.frame_end;
		end
		if (load_s4 && v_s3) begin
			sum_s4  <= sum_c;
			fend_s4 <= fend_s3;
		end
		if (load_s5 && v_s4) begin
			for (int c = 0; c < NUM_CH; c++) begin
				quot_s5[0][c] <= quot_t'(rectify(sum_s4[0][c], grad_a)) * quot_t'(recip_of(kind));
				quot_s5[1][c] <= quot_t'(rectify(sum_s4[1][c], 1'b1)) * quot_t'(recip_of(kind_b));
			end
			fend_s5 <= fend_s4;
		end
		if (load_s6 && v_s5) begin
			out_s6  <= out_c;
			fend_s6 <= fend_s5;
		end
	end

	assign result.valid     = v_s6;
	assign result.red_out   = out_s6[CH_RED];
	assign result.green_out = out_s6[CH_GREEN];
	assign result.blue_out  = out_s6[CH_BLUE];
	assign result.frame_end = fend_s6;

	// all-positive kernels can never produce a negative sum
	a_positive_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && (kind == KIND_MEAN || kind == KIND_CROSS || kind == KIND_GAUSS ||
		kind == KIND_SOFT) |-> !(sum_s4[0][0] < 0 || sum_s4[0][1] < 0 || sum_s4[0][2] < 0))
		else $error("negative sum from a smoothing kernel");

	a_s5_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !load_s6 |=> v_s5 && $stable(fend_s5))
		else $error("stalled divide stage lost its item");
endmodule

// ===== rtl/rgb_3x3_convolution_filter.sv =====
// Top level of the RGB 3x3 convolution filter: config registers, window and kernel pipeline.
// Depends on rcf_pkg, rcf_if, rcf_window and rcf_kernel.
//
//   channel  dir  payload                                  transfer when
//   pixel    in   red_in, green_in, blue_in                valid && ready
//   result   out  red_out, green_out, blue_out, frame_end  valid && ready
//   cfg      in   index, data                              valid && ready (ready tied high)
//
// One pixel per clock unless result stalls or the buffers clear; results go through s1 to s6.
// Border pixels produce no result; the window drops them between stages s1 and s2.
// After reset both line buffers clear all MAX_WIDTH entries, pixel.ready low meanwhile.
// Stalls on result back up stage by stage; empty stages keep taking pixels.
module rgb_3x3_convolution_filter #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	rcf_pix_if.sink    pixel,
	rcf_res_if.source  result,
	rcf_cfg_if.sink    cfg
);
	import rcf_pkg::*;

	logic [KIND_W-1:0]   kind_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [KIND_W-1:0]   kind_eff;
	logic                win_valid;
	logic                win_ready;
	win_t                win_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_MEAN;
			width_q  <= WIDTH_W'(RESET_WIDTH);
			height_q <= HEIGHT_W'(RESET_HEIGHT);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_FILTER_KIND: begin
					kind_q <= cfg.data[KIND_W-1:0];
				end
				REG_IMAGE_WIDTH: begin
					width_q <= cfg.data[WIDTH_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg.data[HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign kind_eff = (kind_q == KIND_UNUSED) ? KIND_MEAN : kind_q;

	rcf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pixel),
		.image_width  (width_q),
		.image_height (height_q),
		.win_valid    (win_valid),
		.win_data     (win_data),
		.win_ready    (win_ready)
	);

	rcf_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind_eff),
		.win_valid (win_valid),
		.win_data  (win_data),
		.win_ready (win_ready),
		.result    (result)
	);
endmodule
